### hw/rtl/xmltok_pkg.sv
// Shared types, codes and character helpers for the XML markup tokenizer.
package xmltok_pkg;

	localparam int POSITION_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int TDATA_BITS = 32;
	localparam int TUSER_BITS = 3;

	typedef enum logic [3:0] {
		MODE_IDLE         = 4'd0,
		MODE_LT           = 4'd1,
		MODE_LT_BANG      = 4'd2,
		MODE_LT_BANG_DASH = 4'd3,
		MODE_COMMENT      = 4'd4,
		MODE_DECL         = 4'd5,
		MODE_PI           = 4'd6,
		MODE_QUOTED       = 4'd7,
		MODE_BARE         = 4'd8
	} mode_t;

	localparam logic [2:0] KIND_LT     = 3'd0;
	localparam logic [2:0] KIND_GT     = 3'd1;
	localparam logic [2:0] KIND_SLASH  = 3'd2;
	localparam logic [2:0] KIND_EQ     = 3'd3;
	localparam logic [2:0] KIND_STRING = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic ends_bare(input logic [7:0] c);
		return is_space(c) || (c == CH_LT) || (c == CH_GT) || (c == CH_EQ) ||
			(c == CH_SLASH);
	endfunction

endpackage

### hw/rtl/xmltok_lexer.sv
// Input register, lexer mode state and per-byte token decode.
module xmltok_lexer #(
	parameter int POSITION_BITS = xmltok_pkg::POSITION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	output xmltok_pkg::push_t  push,
	input  logic               space_ok
);

	localparam int P = POSITION_BITS;

	logic                    v_s1;
	logic [7:0]              byte_s1;
	logic                    go;
	xmltok_pkg::mode_t       mode_q, nmode;
	logic [P-1:0]            pos_q, npos;
	logic [P-1:0]            begin_q, nbegin;
	logic [1:0]              dash_q, ndash;
	logic [1:0]              cnt;
	logic                    ended;
	logic                    do_idle;
	xmltok_pkg::token_t      t0, t1, tk;
	logic [P-1:0]            pos_inc;
	logic [P-1:0]            str_len;

	function automatic logic [15:0] clamp16(input logic [P-1:0] v);
		logic [P+15:0] wide;
		wide = {16'b0, v};
		if (wide > {{P{1'b0}}, 16'hFFFF})
			return 16'hFFFF;
		return wide[15:0];
	endfunction

	function automatic xmltok_pkg::token_t mk_tok(input logic [2:0] kind,
		input logic [P-1:0] start, input logic [P-1:0] len);
		xmltok_pkg::token_t t;
		t.kind   = kind;
		t.start  = clamp16(start);
		t.length = clamp16(len);
		t.last   = 1'b0;
		return t;
	endfunction

	assign go = v_s1 && space_ok;
	assign s_tready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	assign pos_inc = (pos_q == {P{1'b1}}) ? pos_q : pos_q + P'(1);
	assign str_len = (pos_q >= begin_q) ? pos_q - begin_q : '0;

	always_comb begin
		nmode   = mode_q;
		nbegin  = begin_q;
		ndash   = dash_q;
		cnt     = 2'd0;
		ended   = 1'b0;
		do_idle = 1'b0;
		t0      = '0;
		t1      = '0;
		tk      = '0;

		unique case (mode_q)
			xmltok_pkg::MODE_LT: begin
				if (byte_s1 == xmltok_pkg::CH_BANG) begin
					nmode = xmltok_pkg::MODE_LT_BANG;
				end else if (byte_s1 == xmltok_pkg::CH_QMARK) begin
					nmode = xmltok_pkg::MODE_PI;
					ndash = 2'd0;
				end else begin
					t0 = mk_tok(xmltok_pkg::KIND_LT, begin_q, P'(1));
					cnt = 2'd1;
					do_idle = 1'b1;
				end
			end
			xmltok_pkg::MODE_LT_BANG, xmltok_pkg::MODE_LT_BANG_DASH: begin
				if (byte_s1 == xmltok_pkg::CH_NUL) begin
					ended = 1'b1;
				end else if (byte_s1 == xmltok_pkg::CH_GT) begin
					nmode = xmltok_pkg::MODE_IDLE;
				end else if (byte_s1 == xmltok_pkg::CH_DASH) begin
					if (mode_q == xmltok_pkg::MODE_LT_BANG) begin
						nmode = xmltok_pkg::MODE_LT_BANG_DASH;
					end else begin
						nmode = xmltok_pkg::MODE_COMMENT;
						ndash = 2'd0;
					end
				end else begin
					nmode = xmltok_pkg::MODE_DECL;
				end
			end
			xmltok_pkg::MODE_COMMENT: begin
				if (byte_s1 == xmltok_pkg::CH_NUL) begin
					ended = 1'b1;
				end else if (byte_s1 == xmltok_pkg::CH_DASH) begin
					if (dash_q < 2'd2)
						ndash = dash_q + 2'd1;
				end else if (byte_s1 == xmltok_pkg::CH_GT && dash_q >= 2'd2) begin
					nmode = xmltok_pkg::MODE_IDLE;
					ndash = 2'd0;
				end else begin
					ndash = 2'd0;
				end
			end
			xmltok_pkg::MODE_DECL: begin
				if (byte_s1 == xmltok_pkg::CH_NUL) begin
					ended = 1'b1;
				end else if (byte_s1 == xmltok_pkg::CH_GT) begin
					nmode = xmltok_pkg::MODE_IDLE;
				end
			end
			xmltok_pkg::MODE_PI: begin
				if (byte_s1 == xmltok_pkg::CH_NUL) begin
					ended = 1'b1;
				end else if (byte_s1 == xmltok_pkg::CH_QMARK) begin
					ndash = 2'd1;
				end else if (byte_s1 == xmltok_pkg::CH_GT && dash_q != 2'd0) begin
					nmode = xmltok_pkg::MODE_IDLE;
					ndash = 2'd0;
				end else begin
					ndash = 2'd0;
				end
			end
			xmltok_pkg::MODE_QUOTED: begin
				if (byte_s1 == xmltok_pkg::CH_NUL || byte_s1 == xmltok_pkg::CH_QUOTE) begin
					t0 = mk_tok(xmltok_pkg::KIND_STRING, begin_q, str_len);
					cnt = 2'd1;
					nmode = xmltok_pkg::MODE_IDLE;
					ended = (byte_s1 == xmltok_pkg::CH_NUL);
				end
			end
			xmltok_pkg::MODE_BARE: begin
				if (byte_s1 == xmltok_pkg::CH_NUL || xmltok_pkg::ends_bare(byte_s1)) begin
					t0 = mk_tok(xmltok_pkg::KIND_STRING, begin_q, str_len);
					cnt = 2'd1;
					do_idle = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		// between-tokens handling, with any pending token already in slot 0
		if (do_idle) begin
			nmode = xmltok_pkg::MODE_IDLE;
			if (byte_s1 == xmltok_pkg::CH_NUL) begin
				ended = 1'b1;
			end else if (xmltok_pkg::is_space(byte_s1)) begin
				nmode = xmltok_pkg::MODE_IDLE;
			end else if (byte_s1 == xmltok_pkg::CH_LT) begin
				nmode = xmltok_pkg::MODE_LT;
				nbegin = pos_q;
			end else if (byte_s1 == xmltok_pkg::CH_GT) begin
				tk = mk_tok(xmltok_pkg::KIND_GT, pos_q, P'(1));
			end else if (byte_s1 == xmltok_pkg::CH_SLASH) begin
				tk = mk_tok(xmltok_pkg::KIND_SLASH, pos_q, P'(1));
			end else if (byte_s1 == xmltok_pkg::CH_EQ) begin
				tk = mk_tok(xmltok_pkg::KIND_EQ, pos_q, P'(1));
			end else if (byte_s1 == xmltok_pkg::CH_QUOTE) begin
				nmode = xmltok_pkg::MODE_QUOTED;
				nbegin = pos_inc;
			end else begin
				nmode = xmltok_pkg::MODE_BARE;
				nbegin = pos_q;
			end
			if (byte_s1 == xmltok_pkg::CH_GT || byte_s1 == xmltok_pkg::CH_SLASH ||
				byte_s1 == xmltok_pkg::CH_EQ) begin
				if (cnt == 2'd0)
					t0 = tk;
				else
					t1 = tk;
				cnt = cnt + 2'd1;
			end
		end

		// end of text: emit end token and restart
		if (ended) begin
			tk = mk_tok(xmltok_pkg::KIND_END, pos_q, P'(1));
			if (cnt == 2'd0)
				t0 = tk;
			else
				t1 = tk;
			cnt = cnt + 2'd1;
			nmode = xmltok_pkg::MODE_IDLE;
			ndash = 2'd0;
			nbegin = '0;
		end

		if (cnt == 2'd2)
			t1.last = 1'b1;
		else
			t0.last = 1'b1;
	end

	assign npos = ended ? '0 : pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= xmltok_pkg::MODE_IDLE;
			pos_q   <= '0;
			begin_q <= '0;
			dash_q  <= 2'd0;
		end else if (go) begin
			mode_q  <= nmode;
			pos_q   <= npos;
			begin_q <= nbegin;
			dash_q  <= ndash;
		end
	end

	always_comb begin
		push.count = go ? cnt : 2'd0;
		push.tok0  = t0;
		push.tok1  = t1;
	end

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (!push.tok0.last && push.tok1.last))
		else $error("two-token request must flag only the second as last");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ended) |=> (pos_q == '0 && mode_q == xmltok_pkg::MODE_IDLE))
		else $error("position must restart after end of text");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!space_ok |-> (push.count == 2'd0))
		else $error("token request while output queue lacks room");

endmodule

### hw/rtl/xmltok_out_fifo.sv
// Small token queue between the lexer and the output stream port.
module xmltok_out_fifo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  xmltok_pkg::push_t                     push,
	output logic                                  space_ok,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [xmltok_pkg::TDATA_BITS-1:0]     m_tdata,
	output logic [xmltok_pkg::TUSER_BITS-1:0]     m_tuser,
	output logic                                  m_tlast
);

	localparam int D = xmltok_pkg::FIFO_DEPTH;
	localparam int AW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	xmltok_pkg::token_t  mem_q [D];
	logic [AW-1:0]       wp_q, rp_q;
	logic [CW-1:0]       count_q;
	logic                pop;
	xmltok_pkg::token_t  head;

	assign pop = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign space_ok = (count_q <= CW'(D - 2));
	assign head = mem_q[rp_q];
	assign m_tdata = {head.length, head.start};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wp_q] <= push.tok0;
		if (push.count == 2'd2)
			mem_q[wp_q + AW'(1)] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + AW'(push.count);
			rp_q    <= rp_q + AW'(pop);
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D))
		else $error("token queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> ({1'b0, count_q} + (CW + 1)'(push.count) <= (CW + 1)'(D)))
		else $error("token queue overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wp_q == rp_q))
		else $error("empty queue with mismatched pointers");

endmodule

### hw/rtl/xml_markup_tokenizer.sv
// XML markup tokenizer: one text byte in, zero to two token records out.
// Data path: an accepted byte is held in the lexer's input register, decoded there, and its tokens
// are written into the token queue, whose head drives the output port.
// Throughput: one byte per cycle. Input stalls while more than two tokens wait in the
// four-entry token queue, so two-token bytes in a row throttle it.
// Reset (arst_n low, asynchronous): lexer mode between tokens, position zero, queue empty.
module xml_markup_tokenizer #(
	parameter int POSITION_BITS = xmltok_pkg::POSITION_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] text_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [xmltok_pkg::TDATA_BITS-1:0]  m_tdata,  // [15:0] token_start,
	                                                     // [31:16] token_length
	output logic [xmltok_pkg::TUSER_BITS-1:0]  m_tuser,  // [2:0] token_kind
	output logic                               m_tlast   // last_of_run
);

	xmltok_pkg::push_t push;
	logic              space_ok;

	xmltok_lexer #(
		.POSITION_BITS(POSITION_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.space_ok (space_ok)
	);

	xmltok_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### test/xml_markup_tokenizer_tb.sv
// Testbench for the XML markup tokenizer: random XML-like text against a token predictor.
module xml_markup_tokenizer_tb;

	localparam int ITEM_TARGET = 1550;
	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [xmltok_pkg::TDATA_BITS-1:0] m_tdata;
	logic [xmltok_pkg::TUSER_BITS-1:0] m_tuser;
	logic m_tlast;

	xml_markup_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [7:0] pending_bytes[$];
	xmltok_pkg::token_t tokens_due[$];
	xmltok_pkg::token_t head_token;
	int bytes_queued = 0;
	int bytes_offered = 0;
	int bytes_taken = 0;
	int tokens_taken = 0;
	int mismatches = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_drawn_for = 0;
	int hold_order = 0;
	int hold_served = 0;
	int hold_left = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	// tokenizer state as predicted
	xmltok_pkg::mode_t lex_mode = xmltok_pkg::MODE_IDLE;
	logic [15:0] next_pos = '0;
	logic [15:0] mark_pos = '0;
	logic [1:0] dash_cnt = '0;
	logic text_done;
	xmltok_pkg::token_t burst[2];
	int burst_len;

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return c == xmltok_pkg::CH_SPACE || c == xmltok_pkg::CH_TAB ||
			c == xmltok_pkg::CH_CR || c == xmltok_pkg::CH_LF;
	endfunction

	function automatic logic bare_stop(input logic [7:0] c);
		return blank_char(c) || c == xmltok_pkg::CH_LT || c == xmltok_pkg::CH_GT ||
			c == xmltok_pkg::CH_EQ || c == xmltok_pkg::CH_SLASH;
	endfunction

	task automatic add_token(input logic [2:0] kind, input logic [15:0] start,
			input logic [15:0] len);
		if (burst_len < 2) begin
			burst[burst_len].kind = kind;
			burst[burst_len].start = start;
			burst[burst_len].length = len;
			burst[burst_len].last = 1'b0;
			burst_len++;
		end
	endtask

	task automatic close_text(input logic [15:0] pos);
		add_token(xmltok_pkg::KIND_END, pos, 16'd1);
		lex_mode = xmltok_pkg::MODE_IDLE;
		dash_cnt = '0;
		mark_pos = '0;
		text_done = 1'b1;
	endtask

	task automatic between_tokens(input logic [7:0] c, input logic [15:0] pos);
		lex_mode = xmltok_pkg::MODE_IDLE;
		if (c == xmltok_pkg::CH_NUL) begin
			close_text(pos);
		end else if (!blank_char(c)) begin
			case (c)
				xmltok_pkg::CH_LT: begin
					lex_mode = xmltok_pkg::MODE_LT;
					mark_pos = pos;
				end
				xmltok_pkg::CH_GT: add_token(xmltok_pkg::KIND_GT, pos, 16'd1);
				xmltok_pkg::CH_SLASH: add_token(xmltok_pkg::KIND_SLASH, pos, 16'd1);
				xmltok_pkg::CH_EQ: add_token(xmltok_pkg::KIND_EQ, pos, 16'd1);
				xmltok_pkg::CH_QUOTE: begin
					lex_mode = xmltok_pkg::MODE_QUOTED;
					mark_pos = bump(pos);
				end
				default: begin
					lex_mode = xmltok_pkg::MODE_BARE;
					mark_pos = pos;
				end
			endcase
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] c);
		logic [15:0] pos;
		pos = next_pos;
		text_done = 1'b0;
		burst_len = 0;
		case (lex_mode)
			xmltok_pkg::MODE_LT: begin
				if (c == xmltok_pkg::CH_BANG) begin
					lex_mode = xmltok_pkg::MODE_LT_BANG;
				end else if (c == xmltok_pkg::CH_QMARK) begin
					lex_mode = xmltok_pkg::MODE_PI;
					dash_cnt = '0;
				end else begin
					add_token(xmltok_pkg::KIND_LT, mark_pos, 16'd1);
					between_tokens(c, pos);
				end
			end
			xmltok_pkg::MODE_LT_BANG, xmltok_pkg::MODE_LT_BANG_DASH: begin
				if (c == xmltok_pkg::CH_NUL) begin
					close_text(pos);
				end else if (c == xmltok_pkg::CH_GT) begin
					lex_mode = xmltok_pkg::MODE_IDLE;
				end else if (c == xmltok_pkg::CH_DASH) begin
					if (lex_mode == xmltok_pkg::MODE_LT_BANG) begin
						lex_mode = xmltok_pkg::MODE_LT_BANG_DASH;
					end else begin
						lex_mode = xmltok_pkg::MODE_COMMENT;
						dash_cnt = '0;
					end
				end else begin
					lex_mode = xmltok_pkg::MODE_DECL;
				end
			end
			xmltok_pkg::MODE_COMMENT: begin
				if (c == xmltok_pkg::CH_NUL) begin
					close_text(pos);
				end else if (c == xmltok_pkg::CH_DASH) begin
					if (dash_cnt < 2'd2)
						dash_cnt++;
				end else if (c == xmltok_pkg::CH_GT && dash_cnt >= 2'd2) begin
					lex_mode = xmltok_pkg::MODE_IDLE;
					dash_cnt = '0;
				end else begin
					dash_cnt = '0;
				end
			end
			xmltok_pkg::MODE_DECL: begin
				if (c == xmltok_pkg::CH_NUL)
					close_text(pos);
				else if (c == xmltok_pkg::CH_GT)
					lex_mode = xmltok_pkg::MODE_IDLE;
			end
			xmltok_pkg::MODE_PI: begin
				if (c == xmltok_pkg::CH_NUL) begin
					close_text(pos);
				end else if (c == xmltok_pkg::CH_QMARK) begin
					dash_cnt = 2'd1;
				end else if (c == xmltok_pkg::CH_GT && dash_cnt != 2'd0) begin
					lex_mode = xmltok_pkg::MODE_IDLE;
					dash_cnt = '0;
				end else begin
					dash_cnt = '0;
				end
			end
			xmltok_pkg::MODE_QUOTED: begin
				if (c == xmltok_pkg::CH_NUL || c == xmltok_pkg::CH_QUOTE) begin
					add_token(xmltok_pkg::KIND_STRING, mark_pos,
						(pos >= mark_pos) ? pos - mark_pos : 16'd0);
					lex_mode = xmltok_pkg::MODE_IDLE;
					if (c == xmltok_pkg::CH_NUL)
						close_text(pos);
				end
			end
			xmltok_pkg::MODE_BARE: begin
				if (c == xmltok_pkg::CH_NUL || bare_stop(c)) begin
					add_token(xmltok_pkg::KIND_STRING, mark_pos,
						(pos >= mark_pos) ? pos - mark_pos : 16'd0);
					between_tokens(c, pos);
				end
			end
			default: between_tokens(c, pos);
		endcase
		next_pos = text_done ? 16'd0 : bump(pos);
		for (int i = 0; i < burst_len; i++) begin
			burst[i].last = (i == burst_len - 1);
			tokens_due.insert(tokens_due.size(), burst[i]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tokenize_byte(s_tdata);
				bytes_taken++;
			end
			if (m_tvalid && m_tready) begin
				tokens_taken++;
				if (tokens_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected token: kind %0d start %0d length %0d last %0b",
							m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
				end else begin
					head_token = tokens_due.pop_front();
					if (m_tuser !== head_token.kind || m_tdata[15:0] !== head_token.start ||
							m_tdata[31:16] !== head_token.length ||
							m_tlast !== head_token.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("token mismatch: expected kind %0d start %0d length %0d",
								head_token.kind, head_token.start, head_token.length,
								" last %0b, got kind %0d start %0d length %0d last %0b",
								head_token.last, m_tuser, m_tdata[15:0], m_tdata[31:16],
								m_tlast);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || bytes_taken == bytes_offered) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				s_tdata <= pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				bytes_offered++;
				tx_gap = tx_idle ? $urandom_range(0, 9) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_served != hold_order) begin
			hold_served = hold_order;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_drawn_for != tokens_taken) begin
				rx_drawn_for = tokens_taken;
				rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.insert(pending_bytes.size(), b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_word(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 15);
			if (r == 0)
				push_byte(8'($urandom_range(128, 255)));
			else if (r == 1)
				push_byte(xmltok_pkg::CH_QUOTE);
			else
				push_byte(8'h61 + 8'($urandom_range(0, 25)));
		end
	endtask

	task automatic push_blanks(input int n);
		logic [7:0] pick[4];
		pick = '{xmltok_pkg::CH_SPACE, xmltok_pkg::CH_TAB, xmltok_pkg::CH_CR,
			xmltok_pkg::CH_LF};
		for (int i = 0; i < n; i++)
			push_byte(pick[$urandom_range(0, 3)]);
	endtask

	task automatic push_region_body(input logic [7:0] mark, input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 4);
			if (r == 0)
				push_byte(mark);
			else if (r == 1)
				push_byte(xmltok_pkg::CH_GT);
			else if (r == 2)
				push_byte(xmltok_pkg::CH_SPACE);
			else
				push_byte(8'($urandom_range(1, 255)));
		end
	endtask

	task automatic push_piece();
		case ($urandom_range(0, 9))
			0, 1: begin
				push_byte(xmltok_pkg::CH_LT);
				push_word($urandom_range(1, 5));
				repeat ($urandom_range(0, 2)) begin
					push_blanks($urandom_range(1, 2));
					push_word($urandom_range(1, 4));
					push_byte(xmltok_pkg::CH_EQ);
					push_byte(xmltok_pkg::CH_QUOTE);
					push_word($urandom_range(0, 5));
					push_byte(xmltok_pkg::CH_QUOTE);
				end
				push_byte(xmltok_pkg::CH_GT);
			end
			2: begin
				push_text("</");
				push_word($urandom_range(1, 5));
				push_byte(xmltok_pkg::CH_GT);
			end
			3: begin
				push_byte(xmltok_pkg::CH_LT);
				push_word($urandom_range(1, 4));
				push_text("/>");
			end
			4: begin
				push_text("<!--");
				push_region_body(xmltok_pkg::CH_DASH, $urandom_range(0, 8));
				push_text("-->");
			end
			5: begin
				push_text("<!");
				push_word($urandom_range(0, 6));
				push_byte(xmltok_pkg::CH_GT);
			end
			6: begin
				push_text("<?");
				push_region_body(xmltok_pkg::CH_QMARK, $urandom_range(0, 8));
				push_text("?>");
			end
			7: push_blanks($urandom_range(1, 4));
			8: repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(1, 255)));
			default: begin
				if ($urandom_range(0, 1)) begin
					push_word($urandom_range(1, 6));
				end else begin
					push_byte(xmltok_pkg::CH_QUOTE);
					push_word($urandom_range(0, 6));
					push_byte(xmltok_pkg::CH_QUOTE);
				end
			end
		endcase
	endtask

	task automatic push_random_text();
		repeat ($urandom_range(0, 8)) push_piece();
		// cut the text short inside a token or a skipped region
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 7))
				0: push_text("<");
				1: push_text("<!");
				2: push_text("<!-");
				3: push_text("<!--a-");
				4: push_text("<?a?");
				5: push_text("\"ab");
				6: push_word($urandom_range(1, 4));
				default: push_text("<!x");
			endcase
		end
		push_byte(xmltok_pkg::CH_NUL);
	endtask

	task automatic wait_drained();
		while (bytes_taken != bytes_queued || tokens_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit held;
		held = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		push_text("<a x=\"q\"/>");
		push_byte(8'hFF);
		push_text(" <");
		push_byte(xmltok_pkg::CH_NUL);
		push_text("<!-->\"u");
		push_byte(xmltok_pkg::CH_NUL);
		push_text("<?>x");
		push_byte(xmltok_pkg::CH_NUL);
		push_text("\"open");
		push_byte(xmltok_pkg::CH_NUL);
		wait_drained();

		while (bytes_queued < ITEM_TARGET - LONG_RUN) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			push_random_text();
			while (pending_bytes.size() != 0)
				@(negedge clk);
			if (!held && bytes_queued > ITEM_TARGET / 2) begin
				held = 1'b1;
				wait_drained();
				tx_idle = 1'b0;
				repeat (20) push_text("<a/>=");
				push_byte(xmltok_pkg::CH_NUL);
				hold_order++;
				wait_drained();
			end
		end

		// long bare string closed by a blank, then punctuation and a quoted string left open at end of text
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (LONG_RUN) push_byte(8'h61);
		push_text(" \"q\" = z / >\"<");
		push_byte(xmltok_pkg::CH_NUL);
		wait_drained();

		repeat (20) @(negedge clk);
		if (mismatches == 0 && tokens_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/xmltok_pkg.sv
hw/rtl/xmltok_lexer.sv
hw/rtl/xmltok_out_fifo.sv
hw/rtl/xml_markup_tokenizer.sv
test/xml_markup_tokenizer_tb.sv
